/* sv/keyed_byte_mix_sha256_proof_top_macros.svh */
// Assertion macros for the keyed byte mixer
`ifndef KEYED_BYTE_MIX_SHA256_PROOF_TOP_MACROS_SVH
`define KEYED_BYTE_MIX_SHA256_PROOF_TOP_MACROS_SVH
// Assert an implication on the next clock edge
`define KBM_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
// Assert an implication on the same clock edge
`define KBM_ASSERT_NOW(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`endif

/* sv/kbm_pkg.sv */
// Package for the keyed byte mixer: types, constants, SHA-256 functions and a byte rotation
`timescale 1ns / 1ps
package kbm_pkg;
	localparam int StoreBytes = 32;
	localparam int IdxW = 5;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 64;
	localparam int NumSecret = 4;
	localparam int SecretIdxW = 2;
	localparam int SchedWords = 16;
	localparam int RoundW = 6;

	typedef logic [7:0] byte_t;
	typedef logic [31:0] word_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic is_last;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic [1:0] word_index;
		logic last_word;
	} out_beat_t;

	typedef enum logic [2:0] {
		ST_MIX = 3'b001,
		ST_ROUND = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	localparam word_t InitialH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	function automatic word_t round_k(input logic [RoundW-1:0] t);
		word_t k;
		case (t)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic word_t rotr(input word_t v, input int s);
		return (v >> s) | (v << (32 - s));
	endfunction

	function automatic byte_t rotl8(input byte_t x, input logic [2:0] r);
		logic [15:0] d;
		d = {x, x} << r;
		return d[15:8];
	endfunction
endpackage

/* sv/kbm_stream_if.sv */
// Valid/ready stream interface
`timescale 1ns / 1ps
interface kbm_stream_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* sv/keyed_byte_mix_sha256_proof_top.sv */
// Top level of the keyed byte mixer with SHA-256 digest
// channel  | dir | payload
// in_ch    | in  | data_byte[7:0], is_last
// out_ch   | out | digest_word[63:0], word_index[1:0], last_word
// cfg      | in  | cfg_we, cfg_index[2:0], cfg_data[63:0]
// Bytes are taken back to back in ST_MIX; the store sits in flip-flops.
// A last byte adds a pass through ST_ROUND and 4 output beats; the schedule rolls in 16 words.
// The one shared round unit sets the hash time.
// Reset clears state and marks the next byte as message start.
// Output beats hold while ready is low; input is not taken meanwhile.
`timescale 1ns / 1ps
module keyed_byte_mix_sha256_proof_top (
	input logic clk,
	input logic arst_n,
	kbm_stream_if.sink in_ch,
	kbm_stream_if.source out_ch,
	input logic cfg_we,
	input logic [kbm_pkg::CfgIdxW-1:0] cfg_index,
	input logic [kbm_pkg::CfgDataW-1:0] cfg_data
);
	logic [63:0] secret_q [kbm_pkg::NumSecret];
	kbm_pkg::byte_t store_q [kbm_pkg::StoreBytes];
	kbm_pkg::word_t w_q [kbm_pkg::SchedWords];
	kbm_pkg::word_t h_q [8];
	kbm_pkg::state_t state_q;
	logic start_q;
	logic [kbm_pkg::RoundW-1:0] t_q;
	logic [1:0] widx_q;
	kbm_pkg::byte_t cur [kbm_pkg::StoreBytes];
	kbm_pkg::byte_t b;
	logic [kbm_pkg::IdxW-1:0] i, ip1;
	kbm_pkg::byte_t mixed;
	kbm_pkg::word_t s0, s1, wnew, t1, t2, ch, maj;
	logic in_fire;

	assign in_ch.ready = (state_q == kbm_pkg::ST_MIX);
	assign in_fire = in_ch.valid && in_ch.ready;
	assign b = in_ch.payload.data_byte;
	assign i = b[kbm_pkg::IdxW-1:0];
	assign ip1 = i + 1'b1;

	always_comb begin
		for (int k = 0; k < kbm_pkg::StoreBytes; k++) begin
			cur[k] = start_q ? secret_q[k / 8][8 * (k % 8) +: 8] : store_q[k];
		end
		mixed = kbm_pkg::rotl8(b ^ cur[i], cur[ip1][2:0]);
	end

	always_comb begin
		s0 = kbm_pkg::rotr(w_q[1], 7) ^ kbm_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = kbm_pkg::rotr(w_q[14], 17) ^ kbm_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wnew = w_q[0] + s0 + w_q[9] + s1;
		ch = (h_q[4] & h_q[5]) ^ (~h_q[4] & h_q[6]);
		maj = (h_q[0] & h_q[1]) ^ (h_q[0] & h_q[2]) ^ (h_q[1] & h_q[2]);
		t1 = h_q[7] + (kbm_pkg::rotr(h_q[4], 6) ^ kbm_pkg::rotr(h_q[4], 11)
			^ kbm_pkg::rotr(h_q[4], 25)) + ch + kbm_pkg::round_k(t_q) + w_q[0];
		t2 = (kbm_pkg::rotr(h_q[0], 2) ^ kbm_pkg::rotr(h_q[0], 13)
			^ kbm_pkg::rotr(h_q[0], 22)) + maj;
	end

	assign out_ch.valid = (state_q == kbm_pkg::ST_EMIT);
	assign out_ch.payload.digest_word = {kbm_pkg::InitialH[{widx_q, 1'b0}] + h_q[{widx_q, 1'b0}],
		kbm_pkg::InitialH[{widx_q, 1'b1}] + h_q[{widx_q, 1'b1}]};
	assign out_ch.payload.word_index = widx_q;
	assign out_ch.payload.last_word = (widx_q == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < kbm_pkg::NumSecret; k++) secret_q[k] <= '0;
		end else if (cfg_we && (cfg_index < kbm_pkg::CfgIdxW'(kbm_pkg::NumSecret))) begin
			secret_q[cfg_index[kbm_pkg::SecretIdxW-1:0]] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kbm_pkg::ST_MIX;
			start_q <= 1'b1;
			t_q <= '0;
			widx_q <= '0;
		end else begin
			case (state_q)
				kbm_pkg::ST_MIX: begin
					if (in_fire) begin
						start_q <= in_ch.payload.is_last;
						if (in_ch.payload.is_last) begin
							state_q <= kbm_pkg::ST_ROUND;
							t_q <= '0;
						end
					end
				end
				kbm_pkg::ST_ROUND: begin
					t_q <= t_q + 1'b1;
					if (t_q == 6'd63) begin
						state_q <= kbm_pkg::ST_EMIT;
						widx_q <= '0;
					end
				end
				kbm_pkg::ST_EMIT: begin
					if (out_ch.ready) begin
						widx_q <= widx_q + 1'b1;
						if (widx_q == 2'd3) state_q <= kbm_pkg::ST_MIX;
					end
				end
				default: state_q <= kbm_pkg::ST_MIX;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int k = 0; k < kbm_pkg::StoreBytes; k++) begin
				store_q[k] <= (k == int'(i)) ? mixed : cur[k];
			end
			for (int k = 0; k < 8; k++) begin
				w_q[k] <= {(4*k == int'(i)) ? mixed : cur[4*k],
					(4*k+1 == int'(i)) ? mixed : cur[4*k+1],
					(4*k+2 == int'(i)) ? mixed : cur[4*k+2],
					(4*k+3 == int'(i)) ? mixed : cur[4*k+3]};
			end
			w_q[8] <= 32'h80000000;
			for (int k = 9; k < 15; k++) w_q[k] <= '0;
			w_q[15] <= 32'd256;
			for (int k = 0; k < 8; k++) h_q[k] <= kbm_pkg::InitialH[k];
		end else if (state_q == kbm_pkg::ST_ROUND) begin
			for (int k = 0; k < kbm_pkg::SchedWords - 1; k++) w_q[k] <= w_q[k+1];
			w_q[kbm_pkg::SchedWords-1] <= wnew;
			h_q[7] <= h_q[6];
			h_q[6] <= h_q[5];
			h_q[5] <= h_q[4];
			h_q[4] <= h_q[3] + t1;
			h_q[3] <= h_q[2];
			h_q[2] <= h_q[1];
			h_q[1] <= h_q[0];
			h_q[0] <= t1 + t2;
		end
	end
endmodule

/* sv/kbm_checker.sv */
// Port-level checker for the keyed byte mixer, bound to the top level
`timescale 1ns / 1ps
`include "keyed_byte_mix_sha256_proof_top_macros.svh"
module kbm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] word_index,
	input logic last_word
);
	`KBM_ASSERT_NOW(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	`KBM_ASSERT_NOW(a_last_flag, clk, arst_n, out_valid, last_word == (word_index == 2'd3))
	`KBM_ASSERT_NEXT(a_idx_step, clk, arst_n, out_valid && out_ready && word_index != 2'd3,
		out_valid && word_index == $past(word_index) + 2'd1)
	`KBM_ASSERT_NEXT(a_back_to_in, clk, arst_n, out_valid && out_ready && last_word,
		in_ready && !out_valid)
endmodule

bind keyed_byte_mix_sha256_proof_top kbm_checker u_kbm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.word_index(out_ch.payload.word_index),
	.last_word(out_ch.payload.last_word)
);
